[src/lpab_pkg.sv]
`timescale 1ns / 1ps

package lpab_pkg;

  // Number of distinct pixel codes that one input transaction can carry.
  localparam int unsigned CODE_VALUES   = 256;
  localparam int unsigned CODE_W        = 8;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned PROD_W        = 2 * WORD_W;

  localparam int unsigned TABLE_ENTRIES_DEF = 256;
  localparam int unsigned FRAC_BITS_DEF     = 16;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W       = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS        = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEEP_WEIGHT = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEW_WEIGHT  = 8'd3;

  localparam logic signed [WORD_W-1:0] GAIN_RST        = 32'sd65536;
  localparam logic signed [WORD_W-1:0] BIAS_RST        = 32'sd0;
  localparam logic signed [WORD_W-1:0] KEEP_WEIGHT_RST = 32'sd0;
  localparam logic signed [WORD_W-1:0] NEW_WEIGHT_RST  = 32'sd65536;

  // Transaction kinds.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  localparam logic signed [WORD_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [WORD_W-1:0] SAT_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic                     func;
    logic [CODE_W-1:0]        pixel_code;
    logic signed [WORD_W-1:0] table_word;
    logic signed [WORD_W-1:0] old_value;
    logic                     frame_end_in;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] new_value;
    logic                     frame_end_out;
  } out_t;

  // Rounds a full product to nearest (ties toward plus infinity) after
  // dropping frac fraction bits, then clamps it to the 32-bit range.
  function automatic logic signed [WORD_W-1:0] round_sat(
    input logic signed [PROD_W-1:0] prod,
    input int unsigned              frac
  );
    logic signed [PROD_W-1:0] half;
    logic signed [PROD_W-1:0] shifted;
    half    = 64'sd1 <<< (frac - 1);
    shifted = (prod + half) >>> frac;
    if (shifted > 64'(SAT_MAX)) begin
      return SAT_MAX;
    end else if (shifted < 64'(SAT_MIN)) begin
      return SAT_MIN;
    end
    return shifted[WORD_W-1:0];
  endfunction

  // Adds two 32-bit values and clamps the sum to the 32-bit range.
  function automatic logic signed [WORD_W-1:0] add_sat(
    input logic signed [WORD_W-1:0] a,
    input logic signed [WORD_W-1:0] b
  );
    logic signed [WORD_W:0] sum;
    sum = {a[WORD_W-1], a} + {b[WORD_W-1], b};
    if (sum[WORD_W] != sum[WORD_W-1]) begin
      return sum[WORD_W] ? SAT_MIN : SAT_MAX;
    end
    return sum[WORD_W-1:0];
  endfunction

endpackage

[src/lut_pixel_axpby_blend.sv]
`timescale 1ns / 1ps
// An accepted pixel enters stage 0 and moves on through stages 1 to 6. Throughput: one
// transaction per cycle while the output is not stalled; seven elastic register stages,
// each with its own valid bit, and the 32x32 multipliers between them set the stage depth.
// Reset: the weights and offsets return to their defaults, the pipeline empties and every
// lookup entry reads as zero at once through per-entry valid bits; no clearing pass runs.
module lut_pixel_axpby_blend #(
  parameter int unsigned TABLE_ENTRIES = lpab_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned FRAC_BITS     = lpab_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  lpab_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output lpab_pkg::out_t                      out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lpab_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lpab_pkg::WORD_W-1:0]         cfg_data_i
);
  import lpab_pkg::*;

  // Only as many entries as there are pixel codes can ever be reached, since the
  // code is folded onto the table by a modulo.
  localparam int unsigned DEPTH = (TABLE_ENTRIES < CODE_VALUES) ? TABLE_ENTRIES : CODE_VALUES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned NSTG  = 7;

  // ---------------------------------------------------------------------------
  // Configuration registers. The user must make writes arrive only while the block is idle;
  // the block itself does not enforce this, and the stages read these registers directly.
  // ---------------------------------------------------------------------------
  logic signed [WORD_W-1:0] gain_q, bias_q, keep_q, neww_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RST;
      bias_q <= BIAS_RST;
      keep_q <= KEEP_WEIGHT_RST;
      neww_q <= NEW_WEIGHT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_GAIN:        gain_q <= cfg_data_i;
        CFG_BIAS:        bias_q <= cfg_data_i;
        CFG_KEEP_WEIGHT: keep_q <= cfg_data_i;
        CFG_NEW_WEIGHT:  neww_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage control. Each stage loads when it is empty or when the stage after it
  // moves on, so bubbles collapse and a stalled output does not block the input
  // until the whole pipeline is full.
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld_q;
  logic [NSTG-1:0] en;

  always_comb begin
    en[NSTG-1] = !vld_q[NSTG-1] || out_ready_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  logic in_acc, tbl_wr, pix_rd;
  assign in_acc = in_valid_i && in_ready_o;
  assign tbl_wr = in_acc && (in_data_i.func == FUNC_WRITE);
  assign pix_rd = in_acc && (in_data_i.func == FUNC_PIXEL);

  // A table write produces no result, so only pixel transactions occupy a stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= pix_rd;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Lookup table. The pixel code is folded onto the table by a constant map.
  // Reads and writes both happen at the accepting edge, in transaction order,
  // so a pixel always sees every earlier table write.
  // ---------------------------------------------------------------------------
  logic [AW-1:0] addr_map [CODE_VALUES];

  for (genvar i = 0; i < CODE_VALUES; i++) begin : g_addr_map
    assign addr_map[i] = AW'(i % TABLE_ENTRIES);
  end

  logic [AW-1:0]     tbl_addr;
  logic [WORD_W-1:0] tbl_mem [DEPTH];
  logic [DEPTH-1:0]  ent_vld_q;

  assign tbl_addr = addr_map[in_data_i.pixel_code];

  always_ff @(posedge clk_i) begin
    if (tbl_wr) begin
      tbl_mem[tbl_addr] <= in_data_i.table_word;
    end
  end

  // An entry that was never written since reset reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
    end else if (tbl_wr) begin
      ent_vld_q[tbl_addr] <= 1'b1;
    end
  end

  // Stage 0: registered table read plus the pixel side information.
  logic [WORD_W-1:0]        s0_raw_q;
  logic                     s0_hit_q;
  logic signed [WORD_W-1:0] s0_old_q;
  logic                     s0_fe_q;

  always_ff @(posedge clk_i) begin
    if (en[0] && pix_rd) begin
      s0_raw_q <= tbl_mem[tbl_addr];
      s0_hit_q <= ent_vld_q[tbl_addr];
      s0_old_q <= in_data_i.old_value;
      s0_fe_q  <= in_data_i.frame_end_in;
    end
  end

  // Stage 1: both first-level products, word times gain and old value times
  // the keep weight, taken exactly.
  logic signed [WORD_W-1:0] s0_word;
  logic signed [PROD_W-1:0] s1_pword_q, s1_pold_q;
  logic                     s1_fe_q;

  assign s0_word = s0_hit_q ? s0_raw_q : '0;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      s1_pword_q <= PROD_W'(s0_word) * PROD_W'(gain_q);
      s1_pold_q  <= PROD_W'(keep_q) * PROD_W'(s0_old_q);
      s1_fe_q    <= s0_fe_q;
    end
  end

  // Stage 2: round and saturate both products.
  logic signed [WORD_W-1:0] s2_rword_q, s2_a_q;
  logic                     s2_fe_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      s2_rword_q <= round_sat(s1_pword_q, FRAC_BITS);
      s2_a_q     <= round_sat(s1_pold_q, FRAC_BITS);
      s2_fe_q    <= s1_fe_q;
    end
  end

  // Stage 3: add the bias to form the converted pixel value.
  logic signed [WORD_W-1:0] s3_tmp_q, s3_a_q;
  logic                     s3_fe_q;

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      s3_tmp_q <= add_sat(s2_rword_q, bias_q);
      s3_a_q   <= s2_a_q;
      s3_fe_q  <= s2_fe_q;
    end
  end

  // Stage 4: weight the converted value.
  logic signed [PROD_W-1:0] s4_pnew_q;
  logic signed [WORD_W-1:0] s4_a_q;
  logic                     s4_fe_q;

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      s4_pnew_q <= PROD_W'(neww_q) * PROD_W'(s3_tmp_q);
      s4_a_q    <= s3_a_q;
      s4_fe_q   <= s3_fe_q;
    end
  end

  // Stage 5: round and saturate the weighted converted value.
  logic signed [WORD_W-1:0] s5_b_q, s5_a_q;
  logic                     s5_fe_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      s5_b_q  <= round_sat(s4_pnew_q, FRAC_BITS);
      s5_a_q  <= s4_a_q;
      s5_fe_q <= s4_fe_q;
    end
  end

  // Stage 6: the blended sum, which is also the output register.
  logic signed [WORD_W-1:0] s6_res_q;
  logic                     s6_fe_q;

  always_ff @(posedge clk_i) begin
    if (en[6]) begin
      s6_res_q <= add_sat(s5_a_q, s5_b_q);
      s6_fe_q  <= s5_fe_q;
    end
  end

  assign out_valid_o              = vld_q[NSTG-1];
  assign out_data_o.new_value     = s6_res_q;
  assign out_data_o.frame_end_out = s6_fe_q;

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import lpab_pkg::*;

  // The table has as many entries as there are pixel codes, so a code always
  // addresses its own entry for reads and writes alike.
  localparam int unsigned FRAC          = FRAC_BITS_DEF;
  // Extra wait in drain_pipeline after the last owed pixel, before the block is used again.
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned PHASE_ITEMS   = 240;
  localparam int unsigned NUM_PHASES    = 8;
  localparam logic signed [WORD_W-1:0] ONE_Q = 32'sd65536;
  localparam longint WORD_MAX = 64'sd2147483647;
  localparam longint WORD_MIN = -64'sd2147483648;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  logic                 clk       = 1'b0;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  in_t                  in_data   = '0;
  logic                 out_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [WORD_W-1:0]    cfg_data  = '0;

  logic  in_ready_o;
  logic  out_valid_o;
  out_t  out_data_o;
  logic  cfg_ready_o;

  lut_pixel_axpby_blend dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // Our own copy of the block state: the lookup table and the four configuration registers.
  logic signed [WORD_W-1:0] lut_copy [CODE_VALUES];
  logic signed [WORD_W-1:0] gain_r;
  logic signed [WORD_W-1:0] bias_r;
  logic signed [WORD_W-1:0] keep_r;
  logic signed [WORD_W-1:0] mix_r;

  // Blended pixel values still owed by the block, oldest first.
  out_t pending_pixels [$];

  // Codes written lately; random reads favor them so that written entries get read back.
  logic [CODE_W-1:0] recent_codes [8];

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned mismatch_count  = 0;
  int unsigned quiet_cycles    = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  function automatic logic signed [WORD_W-1:0] clamp_word(input longint v);
    if (v > WORD_MAX) begin
      return WORD_MAX[WORD_W-1:0];
    end else if (v < WORD_MIN) begin
      return WORD_MIN[WORD_W-1:0];
    end
    return v[WORD_W-1:0];
  endfunction

  // Exact 64-bit product, round half up at the binary point, then clamp.
  function automatic logic signed [WORD_W-1:0] scale_round(
    input logic signed [WORD_W-1:0] a,
    input logic signed [WORD_W-1:0] b
  );
    longint prod;
    prod = longint'(a) * longint'(b);
    prod = (prod + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
    return clamp_word(prod);
  endfunction

  // Converts one pixel through the table and blends it with the old value.
  function automatic out_t blend_pixel(input in_t item);
    logic signed [WORD_W-1:0] level;
    logic signed [WORD_W-1:0] converted;
    logic signed [WORD_W-1:0] kept;
    logic signed [WORD_W-1:0] fresh;
    out_t res;
    level     = lut_copy[item.pixel_code];
    converted = clamp_word(longint'(scale_round(level, gain_r)) + longint'(bias_r));
    kept      = scale_round(keep_r, item.old_value);
    fresh     = scale_round(mix_r, converted);
    res.new_value     = clamp_word(longint'(kept) + longint'(fresh));
    res.frame_end_out = item.frame_end_in;
    return res;
  endfunction

  // ------------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------------

  // A uniform value in [-span, span].
  function automatic logic signed [WORD_W-1:0] small_q(input int unsigned span);
    return 32'($urandom_range(0, 2 * span)) - 32'(span);
  endfunction

  // Mixes full-range words with the extremes, values near one and rounding ties.
  function automatic logic signed [WORD_W-1:0] random_level();
    case ($urandom_range(0, 5))
      0:       return $urandom();
      1:       return SAT_MAX;
      2:       return SAT_MIN;
      3:       return small_q(32'h2_0000);
      4:       return small_q(1);
      default: return $urandom_range(0, 1) ? 32'sh8000 : -32'sh8000;
    endcase
  endfunction

  function automatic in_t make_item(
    input logic                     func,
    input logic [CODE_W-1:0]        code,
    input logic signed [WORD_W-1:0] word,
    input logic signed [WORD_W-1:0] old,
    input logic                     last
  );
    in_t item;
    item.func         = func;
    item.pixel_code   = code;
    item.table_word   = word;
    item.old_value    = old;
    item.frame_end_in = last;
    return item;
  endfunction

  task automatic set_idling(input idle_mode_e mode);
    sender_idle_pct = (mode == IDLE_SENDER) ? 62 : (mode == IDLE_BOTH) ? 14 : 0;
    recv_stall_pct  = (mode == IDLE_RECEIVER) ? 62 : (mode == IDLE_BOTH) ? 14 : 0;
  endtask

  // Sends one input transaction. Valid is left high on return, so a following
  // call with no idle gap keeps the channel busy without a bubble. The model is
  // updated at the edge that accepts the transaction, which keeps it in step
  // with the block's own ordering of table writes and reads.
  task automatic apply_input(input in_t item);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready_o);
    if (item.func == FUNC_WRITE) begin
      lut_copy[item.pixel_code] = item.table_word;
      recent_codes[3'($urandom_range(0, 7))] = item.pixel_code;
    end else begin
      pending_pixels.push_back(blend_pixel(item));
    end
  endtask

  // Stops sending, waits for every owed pixel, then idles for the settle time before
  // anything else touches the block.
  task automatic drain_pipeline();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] wdata);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= wdata;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_GAIN:        gain_r = wdata;
      CFG_BIAS:        bias_r = wdata;
      CFG_KEEP_WEIGHT: keep_r = wdata;
      CFG_NEW_WEIGHT:  mix_r  = wdata;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Writes all four registers on an idle block. A write to an index past the
  // register list rides along each time; the block must ignore it.
  task automatic set_config(
    input logic signed [WORD_W-1:0] gain,
    input logic signed [WORD_W-1:0] bias,
    input logic signed [WORD_W-1:0] keep,
    input logic signed [WORD_W-1:0] mix
  );
    drain_pipeline();
    cfg_write(CFG_IDX_W'($urandom_range(CFG_NEW_WEIGHT + 1, (1 << CFG_IDX_W) - 1)),
              $urandom());
    cfg_write(CFG_GAIN, gain);
    cfg_write(CFG_BIAS, bias);
    cfg_write(CFG_KEEP_WEIGHT, keep);
    cfg_write(CFG_NEW_WEIGHT, mix);
  endtask

  task automatic note_mismatch(
    input string       what,
    input logic [31:0] want,
    input logic [31:0] got
  );
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, want, got);
    end
  endtask

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------

  // After reset every entry must read as zero, and with the default weights a
  // zero entry blends to zero whatever the old value is.
  task automatic test_cleared_table();
    set_idling(IDLE_NONE);
    apply_input(make_item(FUNC_PIXEL, 8'h00, $urandom(), SAT_MAX, 1'b1));
    apply_input(make_item(FUNC_PIXEL, 8'hFF, $urandom(), SAT_MIN, 1'b0));
    apply_input(make_item(FUNC_PIXEL, 8'h5A, $urandom(), $urandom(), 1'b1));
  endtask

  // With a raw gain and keep weight of one LSB each product sits on a half
  // step, so these transactions land exactly on rounding ties of both signs.
  task automatic test_rounding_ties();
    set_config(32'sd1, 32'sd0, 32'sd1, ONE_Q);
    apply_input(make_item(FUNC_WRITE, 8'h01, 32'sh8000, $urandom(), 1'b1));
    apply_input(make_item(FUNC_WRITE, 8'h02, -32'sh8000, $urandom(), 1'b0));
    apply_input(make_item(FUNC_WRITE, 8'h03, 32'sh1_8000, $urandom(), 1'b1));
    apply_input(make_item(FUNC_WRITE, 8'h04, -32'sh1_8000, $urandom(), 1'b0));
    apply_input(make_item(FUNC_PIXEL, 8'h01, $urandom(), 32'sh8000, 1'b0));
    apply_input(make_item(FUNC_PIXEL, 8'h02, $urandom(), -32'sh8000, 1'b1));
    apply_input(make_item(FUNC_PIXEL, 8'h03, $urandom(), 32'sh1_8000, 1'b0));
    apply_input(make_item(FUNC_PIXEL, 8'h04, $urandom(), -32'sh1_8000, 1'b0));
  endtask

  // Extreme entries under extreme weights drive every product, the offset
  // addition and the final sum into saturation in both directions.
  task automatic test_saturation();
    apply_input(make_item(FUNC_WRITE, 8'hFF, SAT_MAX, $urandom(), 1'b1));
    apply_input(make_item(FUNC_WRITE, 8'h00, SAT_MIN, $urandom(), 1'b0));
    set_config(SAT_MAX, SAT_MAX, SAT_MIN, SAT_MIN);
    apply_input(make_item(FUNC_PIXEL, 8'hFF, $urandom(), SAT_MAX, 1'b1));
    apply_input(make_item(FUNC_PIXEL, 8'h00, $urandom(), SAT_MIN, 1'b0));
    set_config(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
    apply_input(make_item(FUNC_PIXEL, 8'hFF, $urandom(), SAT_MIN, 1'b0));
    apply_input(make_item(FUNC_PIXEL, 8'h00, $urandom(), SAT_MAX, 1'b1));
    set_config(ONE_Q, SAT_MAX, ONE_Q, ONE_Q);
    apply_input(make_item(FUNC_PIXEL, 8'hFF, $urandom(), SAT_MAX, 1'b0));
    apply_input(make_item(FUNC_PIXEL, 8'h00, $urandom(), SAT_MIN, 1'b1));
  endtask

  task automatic phase_config(input int unsigned phase);
    case (phase)
      0: set_config(GAIN_RST, BIAS_RST, KEEP_WEIGHT_RST, NEW_WEIGHT_RST);
      1: set_config(32'sh0000_8000, 32'sh0001_4000, 32'sh0000_C000, 32'sh0000_4000);
      2: set_config(SAT_MAX, SAT_MAX, SAT_MAX, SAT_MAX);
      3: set_config(SAT_MIN, SAT_MIN, SAT_MIN, SAT_MIN);
      4: set_config(-32'sh0001_8000, -32'sh0003_0000, -32'sh0000_8000, 32'sh0002_0000);
      5: set_config($urandom(), $urandom(), $urandom(), $urandom());
      6: set_config(small_q(32'h4_0000), small_q(32'h4_0000), small_q(32'h4_0000),
                    small_q(32'h4_0000));
      default: set_config(small_q(3), small_q(32'h1_0000), small_q(3), ONE_Q);
    endcase
  endtask

  // Random traffic: a quarter table writes, the rest pixels, half of which read
  // back recently written entries. Each phase has its own weights and idling
  // pattern, and halfway through the sender holds off until the block is empty.
  task automatic test_random_traffic();
    in_t         item;
    logic        is_write;
    logic [CODE_W-1:0] code;
    for (int unsigned phase = 0; phase < NUM_PHASES; phase++) begin
      phase_config(phase);
      set_idling(idle_mode_e'(phase % 4));
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) begin
          drain_pipeline();
        end
        is_write = ($urandom_range(0, 99) < 25);
        code     = (!is_write && $urandom_range(0, 1)) ?
                   recent_codes[3'($urandom_range(0, 7))] : CODE_W'($urandom_range(0, 255));
        item = make_item(is_write ? FUNC_WRITE : FUNC_PIXEL, code, random_level(),
                         random_level(), $urandom_range(0, 15) == 0);
        apply_input(item);
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // Result checking, receiver stalls and the stall watchdog
  // ------------------------------------------------------------------------

  // All three processes sample at the clock edge, where the block's outputs and
  // our own drives still hold their values from before the edge.
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid_o && out_ready) begin
      if (pending_pixels.size() == 0) begin
        note_mismatch("unexpected result", '0, out_data_o.new_value);
      end else begin
        want = pending_pixels.pop_front();
        if (out_data_o.new_value !== want.new_value) begin
          note_mismatch("new_value", want.new_value, out_data_o.new_value);
        end
        if (out_data_o.frame_end_out !== want.frame_end_out) begin
          note_mismatch("frame_end_out", 32'(want.frame_end_out),
                        32'(out_data_o.frame_end_out));
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Any transaction on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && in_ready_o) || (out_valid_o && out_ready) ||
        (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ------------------------------------------------------------------------
  // Test sequence
  // ------------------------------------------------------------------------

  initial begin
    foreach (lut_copy[i]) begin
      lut_copy[i] = '0;
    end
    foreach (recent_codes[i]) begin
      recent_codes[i] = '0;
    end
    gain_r = GAIN_RST;
    bias_r = BIAS_RST;
    keep_r = KEEP_WEIGHT_RST;
    mix_r  = NEW_WEIGHT_RST;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_cleared_table();
    test_rounding_ties();
    test_saturation();
    test_random_traffic();
    drain_pipeline();

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
